>>> rtl/assert_macros.svh
// concurrent assertion helpers, reset held low disables the check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/cgcs_pkg.sv
`timescale 1ns / 1ps

package cgcs_pkg;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int ROT_W    = 5;
    localparam int GROUP_W  = 4;
    localparam int LINE_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROTATE_AMOUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_SIZE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_LIMIT    = 2'd2;

    // register reset values
    localparam logic [ROT_W-1:0]   ROTATE_RESET = 5'd0;
    localparam logic [GROUP_W-1:0] GROUP_RESET  = 4'd5;
    localparam logic [LINE_W-1:0]  LINE_RESET   = 8'd74;

    // character codes
    localparam logic [BYTE_W-1:0] CHR_SPACE = 8'd32;
    localparam logic [BYTE_W-1:0] CHR_LF    = 8'd10;
    localparam logic [BYTE_W-1:0] CHR_DEL   = 8'd127;
    localparam logic [BYTE_W-1:0] CHR_UC_A  = 8'd65;
    localparam logic [BYTE_W-1:0] CHR_UC_Z  = 8'd90;
    localparam logic [BYTE_W-1:0] CHR_LC_A  = 8'd97;
    localparam logic [BYTE_W-1:0] CHR_LC_Z  = 8'd122;
    localparam logic [ROT_W-1:0]  ALPHA_LEN = 5'd26;
    localparam logic [LINE_W-1:0] LINE_MAX  = 8'd255;

    typedef struct packed {
        logic [ROT_W-1:0]   rotate_amount;
        logic [GROUP_W-1:0] group_size;
        logic [LINE_W-1:0]  line_limit;
    } t_cfg;

    typedef struct packed {
        logic              keep;
        logic [BYTE_W-1:0] code;
    } t_enc;

    typedef struct packed {
        logic              need;
        logic [BYTE_W-1:0] code;
    } t_sep;

endpackage

>>> rtl/cgcs_intf.sv
`timescale 1ns / 1ps

// raw byte channel
interface cgcs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

// cipher text channel
interface cgcs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink (input valid, input out_byte, input last, output ready);
endinterface

// register write channel
interface cgcs_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/cgcs_cfg_regs.sv
`timescale 1ns / 1ps

module cgcs_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cgcs_cfg_if.sink      i_cfg,
    output cgcs_pkg::t_cfg o_cfg
);
    import cgcs_pkg::*;

    t_cfg r_cfg;

    // writes are always taken
    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register file, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rotate_amount <= ROTATE_RESET;
            r_cfg.group_size    <= GROUP_RESET;
            r_cfg.line_limit    <= LINE_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_ROTATE_AMOUNT: r_cfg.rotate_amount <= i_cfg.data[ROT_W-1:0];
                REG_GROUP_SIZE:    r_cfg.group_size    <= i_cfg.data[GROUP_W-1:0];
                REG_LINE_LIMIT:    r_cfg.line_limit    <= i_cfg.data[LINE_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/cgcs_encoder.sv
`timescale 1ns / 1ps

module cgcs_encoder (
    input  logic [7:0]       i_byte,
    input  logic [4:0]       i_rotate,
    output cgcs_pkg::t_enc   o_enc
);
    import cgcs_pkg::*;

    logic             is_upper;
    logic             is_lower;
    logic [ROT_W-1:0] rot_mod;
    logic [ROT_W-1:0] offset;
    logic [ROT_W:0]   sum;
    logic [ROT_W-1:0] letter;

    always_comb begin
        // printable, non-space bytes only
        o_enc.keep = (i_byte > CHR_SPACE) && (i_byte < CHR_DEL);

        is_upper = (i_byte >= CHR_UC_A) && (i_byte <= CHR_UC_Z);
        is_lower = (i_byte >= CHR_LC_A) && (i_byte <= CHR_LC_Z);

        // fold rotation into 0..25
        rot_mod = (i_rotate >= ALPHA_LEN) ? (i_rotate - ALPHA_LEN) : i_rotate;

        // letter position in the alphabet
        offset = is_upper ? ROT_W'(i_byte - CHR_UC_A) : ROT_W'(i_byte - CHR_LC_A);

        // add and wrap once
        sum    = {1'b0, offset} + {1'b0, rot_mod};
        letter = (sum >= {1'b0, ALPHA_LEN}) ? ROT_W'(sum - {1'b0, ALPHA_LEN}) : sum[ROT_W-1:0];

        // letters go out upper case
        if (is_upper || is_lower) begin
            o_enc.code = CHR_UC_A + {3'b000, letter};
        end else begin
            o_enc.code = i_byte;
        end
    end

endmodule

>>> rtl/cgcs_framer.sv
`timescale 1ns / 1ps

module cgcs_framer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cgcs_pkg::t_cfg i_cfg,
    input  logic           i_step,
    output cgcs_pkg::t_sep o_sep
);
    import cgcs_pkg::*;

    logic [GROUP_W-1:0] r_group_count;
    logic [LINE_W-1:0]  r_line_count;
    logic [GROUP_W-1:0] n_group_count;
    logic [LINE_W-1:0]  n_line_count;

    logic [GROUP_W:0]   next_group;
    logic [LINE_W-1:0]  line_inc;
    logic               line_feed;

    // separator decision for the character being emitted
    always_comb begin
        next_group = {1'b0, r_group_count} + 1'b1;
        line_inc   = (r_line_count != LINE_MAX) ? (r_line_count + 1'b1) : r_line_count;
        line_feed  = line_inc > i_cfg.line_limit;

        o_sep.need = next_group >= {1'b0, i_cfg.group_size};
        o_sep.code = line_feed ? CHR_LF : CHR_SPACE;

        n_group_count = r_group_count;
        n_line_count  = r_line_count;
        if (i_step) begin
            if (o_sep.need) begin
                n_group_count = '0;
                n_line_count  = line_feed ? '0 : line_inc;
            end else begin
                n_group_count = next_group[GROUP_W-1:0];
                n_line_count  = line_inc;
            end
        end
    end

    // group and line counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_count <= '0;
            r_line_count  <= '0;
        end else begin
            r_group_count <= n_group_count;
            r_line_count  <= n_line_count;
        end
    end

endmodule

>>> rtl/caesar_grouped_cipher_stream.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Grouped Caesar cipher stream. Takes one byte per cycle on i_in unless the
// output stalls or a separator is pending, and gives cipher text on o_out:
// letters rotated and upper cased, other printable bytes as they are, control
// bytes, space, DEL and bytes above 127 dropped with no transaction. After
// each group a space or, once the line is over the limit, a line feed
// follows; last is low on a character that has a separator behind it. A
// character with a separator holds the input, since the single output
// register sends the two results one after the other. Registers are written
// over i_cfg (0 rotate amount, 1 group size, 2 line limit); the user must
// write them only while the block is idle, which the block does not enforce.
module caesar_grouped_cipher_stream (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cgcs_in_if.sink     i_in,
    cgcs_out_if.source  o_out,
    cgcs_cfg_if.sink    i_cfg
);
    import cgcs_pkg::*;

    t_cfg cfg;
    t_enc enc;
    t_sep sep;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;
    logic              r_sep_pend;
    logic [BYTE_W-1:0] r_sep_code;

    logic out_free;
    logic in_consume;
    logic step;

    cgcs_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    cgcs_encoder u_encoder (
        .i_byte   (r_in_byte),
        .i_rotate (cfg.rotate_amount),
        .o_enc    (enc)
    );

    cgcs_framer u_framer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_step  (step),
        .o_sep   (sep)
    );

    // handshake control
    assign out_free   = !r_out_valid || o_out.ready;
    assign in_consume = r_in_valid && !r_sep_pend && (!enc.keep || out_free);
    assign step       = in_consume && enc.keep;
    assign i_in.ready = !r_in_valid || in_consume;

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.last     = r_out_last;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.in_byte;
        end
    end

    // output register and pending separator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sep_pend  <= 1'b0;
        end else if (out_free) begin
            if (r_sep_pend) begin
                r_out_valid <= 1'b1;
                r_sep_pend  <= 1'b0;
            end else if (step) begin
                r_out_valid <= 1'b1;
                r_sep_pend  <= sep.need;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_sep_pend) begin
                r_out_byte <= r_sep_code;
                r_out_last <= 1'b1;
            end else if (step) begin
                r_out_byte <= enc.code;
                r_out_last <= !sep.need;
                r_sep_code <= sep.code;
            end
        end
    end

    // a pending separator sits behind a character that is not last
    `ASSERT_IMPL(a_pend_has_char, i_clk, i_rst_n, r_sep_pend, r_out_valid && !r_out_last)
    // a non-last result always has its separator queued
    `ASSERT_IMPL(a_char_has_pend, i_clk, i_rst_n, r_out_valid && !r_out_last, r_sep_pend)
    // a stalled character keeps its separator and its value
    `ASSERT_NEXT(a_pend_holds, i_clk, i_rst_n, r_sep_pend && !o_out.ready,
                 r_sep_pend && $stable(r_out_byte))

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import cgcs_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int REPORT_MAX   = 10;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] code;
        logic              last;
    } cipher_char_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cgcs_in_if  in_if ();
    cgcs_out_if out_if ();
    cgcs_cfg_if cfg_if ();

    caesar_grouped_cipher_stream dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // predicted cipher text, oldest first
    cipher_char_t pending_chars [$];

    // shadow registers and counters of the cipher
    logic [ROT_W-1:0]   rot_amt;
    logic [GROUP_W-1:0] grp_size;
    logic [LINE_W-1:0]  line_lim;
    logic [GROUP_W-1:0] grp_count;
    logic [LINE_W-1:0]  line_cnt;

    int fault_count;
    int cycle_count;
    int in_gap_max;
    int out_gap_max;
    int rx_hold;
    cipher_char_t got_char;
    cipher_char_t want_char;
    logic [7:0] boundary_bytes [0:14];

    always #CLK_HALF i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // rotate a letter, upper case it, pass other printables
    function automatic logic [BYTE_W-1:0] rotate_letter(logic [BYTE_W-1:0] c);
        int letter_idx;
        letter_idx = -1;
        if (c >= CHR_UC_A && c <= CHR_UC_Z)
            letter_idx = int'(c) - int'(CHR_UC_A);
        else if (c >= CHR_LC_A && c <= CHR_LC_Z)
            letter_idx = int'(c) - int'(CHR_LC_A);
        if (letter_idx < 0)
            return c;
        letter_idx = (letter_idx + int'(rot_amt)) % int'(ALPHA_LEN);
        return CHR_UC_A + letter_idx[7:0];
    endfunction

    // queue the characters one accepted byte produces
    function automatic void encipher_byte(logic [BYTE_W-1:0] c);
        int next_grp;
        cipher_char_t ch;
        if (c <= CHR_SPACE || c >= CHR_DEL)
            return;
        ch.code = rotate_letter(c);
        ch.last = 1'b1;
        next_grp = int'(grp_count) + 1;
        if (line_cnt < LINE_MAX)
            line_cnt = line_cnt + 1'b1;
        if (next_grp >= int'(grp_size)) begin
            ch.last = 1'b0;
            pending_chars.push_back(ch);
            if (line_cnt > line_lim) begin
                ch.code = CHR_LF;
                line_cnt = '0;
            end else begin
                ch.code = CHR_SPACE;
            end
            ch.last = 1'b1;
            pending_chars.push_back(ch);
            grp_count = '0;
        end else begin
            pending_chars.push_back(ch);
            grp_count = next_grp[GROUP_W-1:0];
        end
    endfunction

    // random text byte, mostly letters, some dropped bytes
    function automatic logic [7:0] pick_text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return CHR_UC_A + 8'($urandom_range(0, 25));
        else if (r < 55)
            return CHR_LC_A + 8'($urandom_range(0, 25));
        else if (r < 85)
            return 8'($urandom_range(33, 126));
        else
            return 8'($urandom_range(0, 255));
    endfunction

    task automatic report_fault(string what, cipher_char_t want, cipher_char_t got);
        if (fault_count < REPORT_MAX)
            $display("%0t %s: expected byte %0d last %0b, got byte %0d last %0b",
                     $realtime, what, want.code, want.last, got.code, got.last);
        fault_count++;
    endtask

    // compare every output transaction with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got_char.code = out_if.out_byte;
            got_char.last = out_if.last;
            if (pending_chars.size() == 0) begin
                want_char = '0;
                report_fault("unexpected output", want_char, got_char);
            end else begin
                want_char = pending_chars.pop_front();
                if (want_char.code !== got_char.code || want_char.last !== got_char.last)
                    report_fault("output mismatch", want_char, got_char);
            end
        end
    end

    // receiver: random stalls, plus long hold-offs on request
    initial begin : receiver
        int gap;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold > 0) begin
                out_if.ready <= 1'b0;
                while (rx_hold > 0) begin
                    @(posedge i_clk);
                    rx_hold--;
                end
            end
            gap = $urandom_range(0, out_gap_max);
            if (gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_if.valid) @(posedge i_clk);
        end
    end

    // offer one byte after a random gap, predict on acceptance
    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.in_byte <= b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        encipher_byte(b);
    endtask

    task automatic send_text(int count);
        repeat (count) send_byte(pick_text_byte());
    endtask

    // block is idle once all output has come and the pipe has drained
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // register write transaction, then valid driven low
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            REG_ROTATE_AMOUNT: rot_amt  = data[ROT_W-1:0];
            REG_GROUP_SIZE:    grp_size = data[GROUP_W-1:0];
            REG_LINE_LIMIT:    line_lim = data[LINE_W-1:0];
            default: ;
        endcase
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // filtering and pass-through under reset settings
    task automatic test_filter_defaults();
        boundary_bytes = '{8'd0, 8'd31, 8'd32, 8'd33, 8'd64, 8'd65, 8'd90, 8'd91,
                           8'd96, 8'd97, 8'd122, 8'd123, 8'd126, 8'd127, 8'd255};
        in_gap_max  = 0;
        out_gap_max = 0;
        foreach (boundary_bytes[i]) send_byte(boundary_bytes[i]);
        send_byte(8'd128);
        wait_idle();
    endtask

    // rotation above 25, group size zero, write to an unused index
    task automatic test_register_edges();
        cfg_write(REG_ROTATE_AMOUNT, 8'd31);
        cfg_write(REG_GROUP_SIZE, 8'd0);
        cfg_write(REG_UNUSED, 8'hff);
        send_byte("A");
        send_byte("z");
        send_byte("M");
        send_byte("!");
        wait_idle();
    endtask

    // smaller group size while a group is partly filled
    task automatic test_group_shrink();
        cfg_write(REG_ROTATE_AMOUNT, 8'd26);
        cfg_write(REG_GROUP_SIZE, 8'd15);
        repeat (4) send_byte(pick_text_byte() | 8'h40);
        wait_idle();
        cfg_write(REG_GROUP_SIZE, 8'd3);
        send_byte("q");
        wait_idle();
    endtask

    // line count sticks at its maximum with the widest limit
    task automatic test_line_saturation();
        in_gap_max  = 2;
        out_gap_max = 2;
        cfg_write(REG_ROTATE_AMOUNT, 8'd13);
        cfg_write(REG_GROUP_SIZE, 8'd15);
        cfg_write(REG_LINE_LIMIT, 8'd255);
        repeat (300) send_byte(8'($urandom_range(33, 126)));
        wait_idle();
        cfg_write(REG_LINE_LIMIT, 8'd254);
        repeat (20) send_byte(8'($urandom_range(33, 126)));
        wait_idle();
    endtask

    // long output stall while input keeps coming, then drain
    task automatic test_output_stall();
        in_gap_max  = 0;
        out_gap_max = 0;
        cfg_write(REG_GROUP_SIZE, 8'd1);
        cfg_write(REG_LINE_LIMIT, 8'd7);
        rx_hold = 200;
        send_text(60);
        wait_idle();
    endtask

    // random settings per phase, extremes favored
    task automatic program_random_setup();
        int r;
        logic [7:0] v;
        r = $urandom_range(0, 3);
        case (r)
            0: v = 8'd0;
            1: v = 8'd25;
            2: v = 8'($urandom_range(26, 31));
            default: v = 8'($urandom_range(0, 25));
        endcase
        v[7:5] = 3'($urandom_range(0, 7));
        cfg_write(REG_ROTATE_AMOUNT, v);
        r = $urandom_range(0, 4);
        case (r)
            0: v = 8'd1;
            1: v = 8'd15;
            2: v = 8'd0;
            default: v = 8'($urandom_range(1, 15));
        endcase
        v[7:4] = 4'($urandom_range(0, 15));
        cfg_write(REG_GROUP_SIZE, v);
        r = $urandom_range(0, 4);
        case (r)
            0: v = 8'd1;
            1: v = 8'd255;
            2: v = 8'($urandom_range(1, 20));
            default: v = 8'($urandom_range(1, 255));
        endcase
        cfg_write(REG_LINE_LIMIT, v);
        if ($urandom_range(0, 3) == 0)
            cfg_write(REG_UNUSED, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_random_text();
        for (int phase = 0; phase < 12; phase++) begin
            program_random_setup();
            case (phase % 4)
                0: begin in_gap_max = 0; out_gap_max = 0; end
                1: begin in_gap_max = 7; out_gap_max = 7; end
                2: begin in_gap_max = 0; out_gap_max = 7; end
                default: begin
                    in_gap_max  = $urandom_range(0, 7);
                    out_gap_max = $urandom_range(0, 7);
                end
            endcase
            send_text(60);
            wait_idle();
        end
    endtask

    initial begin
        fault_count   = 0;
        cycle_count   = 0;
        in_gap_max    = 0;
        out_gap_max   = 0;
        rx_hold       = 0;
        rot_amt       = ROTATE_RESET;
        grp_size      = GROUP_RESET;
        line_lim      = LINE_RESET;
        grp_count     = '0;
        line_cnt      = '0;
        i_rst_n       <= 1'b0;
        in_if.valid   <= 1'b0;
        in_if.in_byte <= '0;
        cfg_if.valid  <= 1'b0;
        cfg_if.index  <= '0;
        cfg_if.data   <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_filter_defaults();
        test_register_edges();
        test_group_shrink();
        test_line_saturation();
        test_output_stall();
        test_random_text();

        wait_idle();
        if (fault_count == 0 && pending_chars.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
